[rtl/fourier_transfer_filter_macros.svh]
// Assertion macros used by the port-level checker of the transfer filter.
`ifndef FOURIER_TRANSFER_FILTER_MACROS_SVH
`define FOURIER_TRANSFER_FILTER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FTF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define FTF_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[rtl/ftf_pkg.sv]
// Types, constants and the sinc table function of the transfer filter.
package ftf_pkg;

   localparam int GRID_DEFAULT = 256;

   localparam int IDX_W   = 8;
   localparam int MAG_W   = 8;
   localparam int X_W     = 16;
   localparam int Q30_W   = 31;
   localparam int COEF_W  = 32;
   localparam int WGT_W   = 20;
   localparam int SCALE_W = 24;
   localparam int CUT_W   = 48;
   localparam int KA_W    = SCALE_W + MAG_W;
   localparam int KSQ_W   = 2 * SCALE_W + 1;
   localparam int KSUM_W  = KSQ_W + 1;
   localparam int PROD_W  = COEF_W + WGT_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CUT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KSCALE0  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KSCALE1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KSCALE2  = 3'd5;

   localparam logic [31:0]      PI_Q30     = 32'd3373259426;
   localparam logic [Q30_W-1:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [X_W-1:0]   SMOOTH_MAX = 16'd32768;
   localparam logic [WGT_W-1:0] W_ONE      = 20'd65536;
   localparam logic [WGT_W-1:0] W_MAX      = 20'hFFFFF;

   // The reciprocal 2^46 / r2 is resolved four quotient bits per stage.
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = WGT_W / DIV_BITS;
   localparam logic [Q30_W-1:0] DIV_REM_INIT = 31'h0400_0000;

   localparam int SINC_STEPS = 6;

   typedef enum logic [1:0] {
      MODE_CIC     = 2'd0,
      MODE_CUT     = 2'd1,
      MODE_CUT_REV = 2'd2,
      MODE_BYPASS  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [X_W-1:0]       smoother;
      logic [Q30_W-1:0]     sinc_smooth;
      logic [CUT_W-1:0]     cut_sq;
      logic [SCALE_W-1:0]   kscale0;
      logic [SCALE_W-1:0]   kscale1;
      logic [SCALE_W-1:0]   kscale2;
   } cfg_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_real;
      logic signed [COEF_W-1:0] coef_imag;
      logic                     pass;
   } side_type;

   // Reciprocals of the series divisors m*(m+1), innermost term first. Together
   // with the shift below, (n * recip) >> shift equals n / (m*(m+1)) exactly for
   // every 32-bit n.
   function automatic logic [32:0] sinc_recip(input logic [2:0] step);
      logic [32:0] r;
      unique case (step)
         3'd0:    r = 33'((64'd1 << 40) / 156 + 1);
         3'd1:    r = 33'((64'd1 << 39) / 110 + 1);
         3'd2:    r = 33'((64'd1 << 39) / 72 + 1);
         3'd3:    r = 33'((64'd1 << 38) / 42 + 1);
         3'd4:    r = 33'((64'd1 << 37) / 20 + 1);
         default: r = 33'((64'd1 << 35) / 6 + 1);
      endcase
      return r;
   endfunction

   function automatic logic [5:0] sinc_shift(input logic [2:0] step);
      logic [5:0] s;
      unique case (step)
         3'd0:    s = 6'd40;
         3'd1:    s = 6'd39;
         3'd2:    s = 6'd39;
         3'd3:    s = 6'd38;
         3'd4:    s = 6'd37;
         default: s = 6'd35;
      endcase
      return s;
   endfunction

   // sinc of a Q0.16 argument as Q1.30, used to build constant tables.
   function automatic longint unsigned sinc_q30(input longint unsigned x);
      longint unsigned t;
      longint unsigned y;
      longint unsigned acc;
      longint unsigned one;
      one = 64'd1 << 30;
      t   = (64'(PI_Q30) * x) >> 16;
      y   = (t * t) >> 30;
      acc = one;
      acc = one - (((y * acc) >> 30) / 156);
      acc = one - (((y * acc) >> 30) / 110);
      acc = one - (((y * acc) >> 30) / 72);
      acc = one - (((y * acc) >> 30) / 42);
      acc = one - (((y * acc) >> 30) / 20);
      acc = one - (((y * acc) >> 30) / 6);
      return acc;
   endfunction

   localparam logic [Q30_W-1:0] SINC_RESET = 31'(sinc_q30(64'd32768));

endpackage

[rtl/ftf_csr.sv]
// Configuration registers and the iterative unit that evaluates sinc(smoother).
module ftf_csr import ftf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  csr_ready,
   output logic                  busy,
   output cfg_type               cfg
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MUL_T   = 5'b00010,
      ST_MUL_Y   = 5'b00100,
      ST_MUL_ACC = 5'b01000,
      ST_DIV     = 5'b10000
   } sinc_state_type;

   sinc_state_type     state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [X_W-1:0]     smoother_ff, smoother_in;
   logic [X_W-1:0]     sarg_ff, sarg_in;
   logic [CUT_W-1:0]   cut_ff, cut_in;
   logic [SCALE_W-1:0] ks0_ff, ks0_in;
   logic [SCALE_W-1:0] ks1_ff, ks1_in;
   logic [SCALE_W-1:0] ks2_ff, ks2_in;
   logic [Q30_W-1:0]   sinc_ff, sinc_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        y_ff, y_in;
   logic [Q30_W-1:0]   acc_ff, acc_in;
   logic [31:0]        num_ff, num_in;
   logic [2:0]         step_ff, step_in;

   logic wr;

   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = !csr_ready;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      logic [47:0] mul_t;
      logic [63:0] mul_sq;
      logic [64:0] mul_rc;
      logic [31:0] quot;
      state_in    = state_ff;
      mode_in     = mode_ff;
      smoother_in = smoother_ff;
      sarg_in     = sarg_ff;
      cut_in      = cut_ff;
      ks0_in      = ks0_ff;
      ks1_in      = ks1_ff;
      ks2_in      = ks2_ff;
      sinc_in     = sinc_ff;
      t_in        = t_ff;
      y_in        = y_ff;
      acc_in      = acc_ff;
      num_in      = num_ff;
      step_in     = step_ff;
      mul_t       = 48'(PI_Q30) * 48'(sarg_ff);
      mul_sq      = '0;
      mul_rc      = 65'(num_ff) * 65'(sinc_recip(step_ff));
      quot        = 32'(mul_rc >> sinc_shift(step_ff));

      if (wr) begin
         unique case (csr_index)
            REG_MODE:     mode_in = mode_type'(csr_data[1:0]);
            REG_SMOOTHER: begin
               smoother_in = csr_data[X_W-1:0];
               sarg_in     = (csr_data[X_W-1:0] > SMOOTH_MAX) ? SMOOTH_MAX
                                                              : csr_data[X_W-1:0];
               state_in    = ST_MUL_T;
            end
            REG_CUT:      cut_in = csr_data[CUT_W-1:0];
            REG_KSCALE0:  ks0_in = csr_data[SCALE_W-1:0];
            REG_KSCALE1:  ks1_in = csr_data[SCALE_W-1:0];
            REG_KSCALE2:  ks2_in = csr_data[SCALE_W-1:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: ;
         ST_MUL_T: begin
            t_in     = mul_t[47:16];
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_sq   = 64'(t_ff) * 64'(t_ff);
            y_in     = mul_sq[61:30];
            acc_in   = ONE_Q30;
            step_in  = '0;
            state_in = ST_MUL_ACC;
         end
         ST_MUL_ACC: begin
            mul_sq   = 64'(y_ff) * 64'(acc_ff);
            num_in   = mul_sq[61:30];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The series divisor is applied as a reciprocal multiply and shift.
            acc_in = ONE_Q30 - quot[Q30_W-1:0];
            if (step_ff == 3'(SINC_STEPS - 1)) begin
               sinc_in  = ONE_Q30 - quot[Q30_W-1:0];
               state_in = ST_IDLE;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_MUL_ACC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_CIC;
         smoother_ff <= SMOOTH_MAX;
         sarg_ff     <= SMOOTH_MAX;
         cut_ff      <= '0;
         ks0_ff      <= '0;
         ks1_ff      <= '0;
         ks2_ff      <= '0;
         sinc_ff     <= SINC_RESET;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         smoother_ff <= smoother_in;
         sarg_ff     <= sarg_in;
         cut_ff      <= cut_in;
         ks0_ff      <= ks0_in;
         ks1_ff      <= ks1_in;
         ks2_ff      <= ks2_in;
         sinc_ff     <= sinc_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      step_ff <= step_in;
   end

   assign cfg.mode        = mode_ff;
   assign cfg.smoother    = smoother_ff;
   assign cfg.sinc_smooth = sinc_ff;
   assign cfg.cut_sq      = cut_ff;
   assign cfg.kscale0     = ks0_ff;
   assign cfg.kscale1     = ks1_ff;
   assign cfg.kscale2     = ks2_ff;

endmodule

[rtl/ftf_axis.sv]
// Per-axis lookup: wrapped frequency, sinc factor and scaled wavenumber.
module ftf_axis import ftf_pkg::*; #(
   parameter int GRID = GRID_DEFAULT
) (
   input  logic [IDX_W-1:0]   idx,
   input  logic [X_W-1:0]     smoother,
   input  logic [Q30_W-1:0]   sinc_smooth,
   input  logic [SCALE_W-1:0] kscale,
   output logic [Q30_W-1:0]   factor,
   output logic [KA_W-1:0]    kprod
);

   localparam int ENTRIES = 1 << IDX_W;

   logic [MAG_W-1:0] mag_tab  [ENTRIES];
   logic [X_W-1:0]   x_tab    [ENTRIES];
   logic [Q30_W-1:0] sinc_tab [ENTRIES];

   for (genvar g = 0; g < ENTRIES; g++) begin : g_tab
      localparam int IMOD = g % GRID;
      localparam int MAG  = (IMOD > GRID / 2) ? GRID - IMOD : IMOD;
      localparam int XQ   = (MAG * 65536) / GRID;
      assign mag_tab[g]  = MAG_W'(MAG);
      assign x_tab[g]    = X_W'(XQ);
      assign sinc_tab[g] = Q30_W'(sinc_q30(64'(XQ)));
   end

   logic [MAG_W-1:0] mag;
   logic [X_W-1:0]   xq;

   assign mag = mag_tab[idx];
   assign xq  = x_tab[idx];

   // A zero frequency contributes a factor of one.
   always_comb begin
      if (mag == '0) begin
         factor = ONE_Q30;
      end else if (xq < smoother) begin
         factor = sinc_tab[idx];
      end else begin
         factor = sinc_smooth;
      end
   end

   assign kprod = KA_W'(kscale) * KA_W'(mag);

endmodule

[rtl/ftf_div_pipe.sv]
// Pipelined restoring divider for the weight 2^46 / r2, saturated to 20 bits.
module ftf_div_pipe import ftf_pkg::*; #(
   parameter int STAGES = DIV_STAGES,
   parameter int BITS   = DIV_BITS,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic [STAGES-1:0] en,
   input  logic [Q30_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [WGT_W-1:0]  quot,
   output logic [SIDE_W-1:0] side_out
);

   logic [Q30_W-1:0]  den_ff  [STAGES];
   logic [Q30_W-1:0]  rem_ff  [STAGES];
   logic [WGT_W-1:0]  q_ff    [STAGES];
   logic              sat_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   logic [Q30_W-1:0]  den_in  [STAGES];
   logic [Q30_W-1:0]  rem_in  [STAGES];
   logic [WGT_W-1:0]  q_in    [STAGES];
   logic              sat_in  [STAGES];
   logic [SIDE_W-1:0] side_in_s [STAGES];

   always_comb begin
      logic [Q30_W:0]   rem_t;
      logic [WGT_W-1:0] q_t;
      for (int j = 0; j < STAGES; j++) begin
         if (j == 0) begin
            den_in[j]    = den;
            sat_in[j]    = (den <= DIV_REM_INIT);
            side_in_s[j] = side_in;
            rem_t        = {1'b0, DIV_REM_INIT};
            q_t          = '0;
         end else begin
            den_in[j]    = den_ff[j-1];
            sat_in[j]    = sat_ff[j-1];
            side_in_s[j] = side_ff[j-1];
            rem_t        = {1'b0, rem_ff[j-1]};
            q_t          = q_ff[j-1];
         end
         for (int b = 0; b < BITS; b++) begin
            rem_t = {rem_t[Q30_W-1:0], 1'b0};
            if (rem_t >= {1'b0, den_in[j]}) begin
               rem_t = rem_t - {1'b0, den_in[j]};
               q_t   = {q_t[WGT_W-2:0], 1'b1};
            end else begin
               q_t   = {q_t[WGT_W-2:0], 1'b0};
            end
         end
         rem_in[j] = rem_t[Q30_W-1:0];
         q_in[j]   = q_t;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (en[j]) begin
            den_ff[j]  <= den_in[j];
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            sat_ff[j]  <= sat_in[j];
            side_ff[j] <= side_in_s[j];
         end
      end
   end

   assign quot     = sat_ff[STAGES-1] ? W_MAX : q_ff[STAGES-1];
   assign side_out = side_ff[STAGES-1];

endmodule

[rtl/ftf_scale.sv]
// Two-stage complex scaling by the weight with floor and 32-bit saturation.
module ftf_scale import ftf_pkg::*; (
   input  logic                     clock,
   input  logic [1:0]               en,
   input  logic [WGT_W-1:0]         w,
   input  logic signed [COEF_W-1:0] coef_real,
   input  logic signed [COEF_W-1:0] coef_imag,
   output logic signed [COEF_W-1:0] out_real,
   output logic signed [COEF_W-1:0] out_imag,
   output logic [WGT_W-1:0]         weight
);

   logic signed [PROD_W-1:0] pr_ff, pr_in;
   logic signed [PROD_W-1:0] pi_ff, pi_in;
   logic [WGT_W-1:0]         wa_ff;
   logic signed [COEF_W-1:0] or_ff, or_in;
   logic signed [COEF_W-1:0] oi_ff, oi_in;
   logic [WGT_W-1:0]         wb_ff;

   function automatic logic signed [COEF_W-1:0] sat_shift(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] q;
      logic [PROD_W-COEF_W:0]   top;
      q   = p >>> 16;
      top = q[PROD_W-1:COEF_W-1];
      if (top == '0 || top == '1) begin
         return q[COEF_W-1:0];
      end else if (q[PROD_W-1]) begin
         return {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COEF_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      pr_in = PROD_W'(coef_real) * PROD_W'($signed({1'b0, w}));
      pi_in = PROD_W'(coef_imag) * PROD_W'($signed({1'b0, w}));
      or_in = sat_shift(pr_ff);
      oi_in = sat_shift(pi_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pr_ff <= pr_in;
         pi_ff <= pi_in;
         wa_ff <= w;
      end
      if (en[1]) begin
         or_ff <= or_in;
         oi_ff <= oi_in;
         wb_ff <= wa_ff;
      end
   end

   assign out_real = or_ff;
   assign out_imag = oi_ff;
   assign weight   = wb_ff;

endmodule

[rtl/fourier_transfer_filter.sv]
// Top level of the transfer filter: per-coefficient weight and complex scaling.
//
// Items enter on the req_ channel (three grid indices and a complex coefficient)
// and leave on the rsp_ channel as the scaled coefficient and the weight used.
// Both channels are valid/ready; one item can be accepted every cycle unless the
// receiver stalls or a sinc evaluation runs. The pipeline is 12 register stages
// deep; five of the stages are the weight reciprocal (four quotient bits each)
// and two the final multiply. Every stage holds a valid bit and moves whenever
// the stage after it is empty or moving, so a stalled receiver backs up the
// pipeline stage by stage and bubbles are squeezed out; nothing is dropped or
// repeated.
// Registers are written through csr_ at index order mode, smoother, cut,
// k_scale 0..2. A smoother write starts a sinc evaluation, and csr_ready and
// req_ready stay low until it is done.
// Synchronous reset empties the pipeline and loads the register defaults.
module fourier_transfer_filter import ftf_pkg::*; #(
   parameter int GRID_AXIS0 = GRID_DEFAULT,
   parameter int GRID_AXIS1 = GRID_DEFAULT,
   parameter int GRID_AXIS2 = GRID_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IDX_W-1:0]         req_index_axis0,
   input  logic [IDX_W-1:0]         req_index_axis1,
   input  logic [IDX_W-1:0]         req_index_axis2,
   input  logic signed [COEF_W-1:0] req_coef_real,
   input  logic signed [COEF_W-1:0] req_coef_imag,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COEF_W-1:0] rsp_out_real,
   output logic signed [COEF_W-1:0] rsp_out_imag,
   output logic [WGT_W-1:0]         rsp_weight
);

   localparam int NS      = 7 + DIV_STAGES;
   localparam int S_DIV   = 5;
   localparam int S_WGT   = S_DIV + DIV_STAGES;
   localparam int SIDE_W  = $bits(side_type);

   cfg_type cfg;
   logic    busy;

   ftf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .busy      (busy),
      .cfg       (cfg)
   );

   // Stage enables ripple back from the output.
   logic [NS:1] v_ff, v_in;
   logic [NS:1] en;
   logic        take;

   always_comb begin
      en[NS] = !v_ff[NS] || rsp_ready;
      for (int k = NS - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1] && !busy;
   assign take      = req_valid && req_ready;

   always_comb begin
      for (int k = 1; k <= NS; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 1) ? take : v_ff[k-1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: table lookups per axis.
   logic [IDX_W-1:0]   idx    [3];
   logic [SCALE_W-1:0] kscale [3];
   logic [Q30_W-1:0]   fac_in [3];
   logic [KA_W-1:0]    ka_in  [3];

   assign idx[0]    = req_index_axis0;
   assign idx[1]    = req_index_axis1;
   assign idx[2]    = req_index_axis2;
   assign kscale[0] = cfg.kscale0;
   assign kscale[1] = cfg.kscale1;
   assign kscale[2] = cfg.kscale2;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      localparam int GRID = (a == 0) ? GRID_AXIS0 : (a == 1) ? GRID_AXIS1 : GRID_AXIS2;
      ftf_axis #(.GRID(GRID)) u_axis (
         .idx         (idx[a]),
         .smoother    (cfg.smoother),
         .sinc_smooth (cfg.sinc_smooth),
         .kscale      (kscale[a]),
         .factor      (fac_in[a]),
         .kprod       (ka_in[a])
      );
   end

   logic [Q30_W-1:0]  fac_ff [3];
   logic [KA_W-1:0]   ka_ff  [3];
   side_type          s1_ff, s1_in;

   // Stage 2: first factor product and the wavenumber squares.
   logic [Q30_W-1:0]  p01_ff, p01_in;
   logic [Q30_W-1:0]  f2_ff;
   logic [KSQ_W-1:0]  ksq_ff [3];
   logic [KSQ_W-1:0]  ksq_in [3];
   side_type          s2_ff;

   // Stage 3: full product and wavenumber sum.
   logic [Q30_W-1:0]  r_ff, r_in;
   logic [KSUM_W-1:0] ksum_ff, ksum_in;
   side_type          s3_ff;

   // Stage 4: squared product and cut decision.
   logic [Q30_W-1:0]  r2_ff, r2_in;
   side_type          s4_ff, s4_in;

   // Stage after the divider: weight select.
   logic [WGT_W-1:0]  w_ff, w_in;
   logic [WGT_W-1:0]  quot;
   logic [SIDE_W-1:0] div_side;
   side_type          sd, s10_ff;

   always_comb begin
      logic [61:0] m01;
      logic [61:0] m012;
      logic [61:0] msq;
      s1_in.coef_real = req_coef_real;
      s1_in.coef_imag = req_coef_imag;
      s1_in.pass      = 1'b0;

      m01    = 62'(fac_ff[0]) * 62'(fac_ff[1]);
      p01_in = m01[60:30];
      for (int a = 0; a < 3; a++) begin
         if (ka_ff[a][KA_W-1:SCALE_W] != '0) begin
            ksq_in[a] = {1'b1, {(KSQ_W-1){1'b0}}};
         end else begin
            ksq_in[a] = KSQ_W'(ka_ff[a][SCALE_W-1:0])
                        * KSQ_W'(ka_ff[a][SCALE_W-1:0]);
         end
      end

      m012    = 62'(p01_ff) * 62'(f2_ff);
      r_in    = m012[60:30];
      ksum_in = KSUM_W'(ksq_ff[0]) + KSUM_W'(ksq_ff[1]) + KSUM_W'(ksq_ff[2]);

      msq        = 62'(r_ff) * 62'(r_ff);
      r2_in      = msq[60:30];
      s4_in      = s3_ff;
      s4_in.pass = (ksum_ff < KSUM_W'(cfg.cut_sq)) ^ (cfg.mode == MODE_CUT_REV);

      sd = side_type'(div_side);
      unique case (cfg.mode)
         MODE_CIC:     w_in = quot;
         MODE_CUT,
         MODE_CUT_REV: w_in = sd.pass ? W_ONE : '0;
         MODE_BYPASS:  w_in = W_ONE;
         default:      w_in = W_ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int a = 0; a < 3; a++) begin
            fac_ff[a] <= fac_in[a];
            ka_ff[a]  <= ka_in[a];
         end
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         p01_ff <= p01_in;
         f2_ff  <= fac_ff[2];
         for (int a = 0; a < 3; a++) begin
            ksq_ff[a] <= ksq_in[a];
         end
         s2_ff <= s1_ff;
      end
      if (en[3]) begin
         r_ff    <= r_in;
         ksum_ff <= ksum_in;
         s3_ff   <= s2_ff;
      end
      if (en[4]) begin
         r2_ff <= r2_in;
         s4_ff <= s4_in;
      end
      if (en[S_WGT]) begin
         w_ff   <= w_in;
         s10_ff <= sd;
      end
   end

   ftf_div_pipe #(
      .STAGES (DIV_STAGES),
      .BITS   (DIV_BITS),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock    (clock),
      .en       (en[S_WGT-1:S_DIV]),
      .den      (r2_ff),
      .side_in  (SIDE_W'(s4_ff)),
      .quot     (quot),
      .side_out (div_side)
   );

   ftf_scale u_scale (
      .clock     (clock),
      .en        (en[NS:NS-1]),
      .w         (w_ff),
      .coef_real (s10_ff.coef_real),
      .coef_imag (s10_ff.coef_imag),
      .out_real  (rsp_out_real),
      .out_imag  (rsp_out_imag),
      .weight    (rsp_weight)
   );

   assign rsp_valid = v_ff[NS];

endmodule

[rtl/ftf_checker.sv]
// Port-level checks of the transfer filter and their bind to the top level.
`include "fourier_transfer_filter_macros.svh"

module ftf_checker import ftf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     csr_ready,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [COEF_W-1:0] rsp_out_real,
   input logic signed [COEF_W-1:0] rsp_out_imag,
   input logic [WGT_W-1:0]         rsp_weight
);

   `FTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp item dropped while stalled")

   `FTF_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_out_real) && $stable(rsp_out_imag) && $stable(rsp_weight), "rsp payload changed while stalled")

   `FTF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid right after reset")

   `FTF_ASSERT(a_zero_weight, clock, reset, rsp_valid && rsp_weight == '0 |-> rsp_out_real == '0 && rsp_out_imag == '0, "nonzero output with zero weight")

   `FTF_ASSERT(a_busy_blocks, clock, reset, req_ready |-> csr_ready, "item taken during sinc evaluation")

endmodule

bind fourier_transfer_filter ftf_checker u_ftf_checker (.*);

[verif/fourier_transfer_filter_checker.sv]
// Checker for the transfer filter: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps
module fourier_transfer_filter_checker import ftf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [IDX_W-1:0]         req_index_axis0,
   input  logic [IDX_W-1:0]         req_index_axis1,
   input  logic [IDX_W-1:0]         req_index_axis2,
   input  logic signed [COEF_W-1:0] req_coef_real,
   input  logic signed [COEF_W-1:0] req_coef_imag,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [COEF_W-1:0] rsp_out_real,
   input  logic signed [COEF_W-1:0] rsp_out_imag,
   input  logic [WGT_W-1:0]         rsp_weight,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [COEF_W-1:0] re;
      logic [COEF_W-1:0] im;
      logic [WGT_W-1:0]  wgt;
   } scaled_type;

   localparam longint unsigned GRID = 256;

   mode_type             cur_mode;
   logic [X_W-1:0]       cur_smoother;
   logic [CUT_W-1:0]     cur_cut;
   logic [SCALE_W-1:0]   cur_scale [3];
   scaled_type           scaled_q [$];

   assign pending = scaled_q.size();

   function automatic longint unsigned sinc_value(input longint unsigned x);
      longint unsigned t;
      longint unsigned y;
      longint unsigned acc;
      longint unsigned m;
      t   = (64'd3373259426 * x) >> 16;
      y   = (t * t) >> 30;
      acc = 64'd1 << 30;
      for (m = 12; m >= 2; m -= 2)
         acc = (64'd1 << 30) - (((y * acc) >> 30) / (m * (m + 1)));
      return acc;
   endfunction

   function automatic longint unsigned wrap_mag(input logic [IDX_W-1:0] idx);
      longint unsigned i;
      i = longint'(idx) % GRID;
      return (i > GRID / 2) ? GRID - i : i;
   endfunction

   function automatic logic [COEF_W-1:0] scale_part(input logic signed [COEF_W-1:0] c,
                                                    input longint unsigned w);
      longint p;
      longint q;
      p = longint'(c) * longint'(w);
      q = p >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[COEF_W-1:0];
   endfunction

   function automatic scaled_type predict_scaled(input logic [IDX_W-1:0] i0, i1, i2,
                                                 input logic signed [COEF_W-1:0] cr, ci);
      longint unsigned mag [3];
      longint unsigned r;
      longint unsigned r2;
      longint unsigned w;
      longint unsigned x;
      longint unsigned clampv;
      longint unsigned a;
      longint unsigned sum;
      logic pass;
      scaled_type s;
      mag[0] = wrap_mag(i0);
      mag[1] = wrap_mag(i1);
      mag[2] = wrap_mag(i2);
      clampv = (cur_smoother > 32768) ? 32768 : cur_smoother;
      case (cur_mode)
         MODE_CIC: begin
            r = 64'd1 << 30;
            for (int k = 0; k < 3; k++) begin
               if (mag[k] != 0) begin
                  x = (mag[k] << 16) / GRID;
                  r = (r * ((x < cur_smoother) ? sinc_value(x) : sinc_value(clampv))) >> 30;
               end
            end
            r2 = (r * r) >> 30;
            w = (r2 == 0) ? 64'hFFFFF : (64'd1 << 46) / r2;
            if (w > 64'hFFFFF) w = 64'hFFFFF;
         end
         MODE_CUT, MODE_CUT_REV: begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
               a = longint'(cur_scale[k]) * mag[k];
               sum += (a >= (64'd1 << 24)) ? (64'd1 << 48) : a * a;
            end
            pass = sum < longint'(cur_cut);
            if (cur_mode == MODE_CUT_REV) pass = !pass;
            w = pass ? 65536 : 0;
         end
         default: w = 65536;
      endcase
      s.re  = scale_part(cr, w);
      s.im  = scale_part(ci, w);
      s.wgt = w[WGT_W-1:0];
      return s;
   endfunction

   always @(posedge clock) begin
      scaled_type got;
      scaled_type want;
      if (reset) begin
         cur_mode     <= MODE_CIC;
         cur_smoother <= 16'd32768;
         cur_cut      <= '0;
         for (int k = 0; k < 3; k++) cur_scale[k] <= '0;
         scaled_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:     cur_mode     <= mode_type'(csr_data[1:0]);
               REG_SMOOTHER: cur_smoother <= csr_data[X_W-1:0];
               REG_CUT:      cur_cut      <= csr_data[CUT_W-1:0];
               REG_KSCALE0:  cur_scale[0] <= csr_data[SCALE_W-1:0];
               REG_KSCALE1:  cur_scale[1] <= csr_data[SCALE_W-1:0];
               REG_KSCALE2:  cur_scale[2] <= csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            scaled_q.push_back(predict_scaled(req_index_axis0, req_index_axis1,
                                              req_index_axis2, req_coef_real, req_coef_imag));
         if (rsp_valid && rsp_ready) begin
            got.re  = rsp_out_real;
            got.im  = rsp_out_imag;
            got.wgt = rsp_weight;
            if (scaled_q.size() == 0) begin
               $error("result with no item outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = scaled_q.pop_front();
               if (got != want) fail_count <= fail_count + 1;
               if (got.re != want.re)
                  $error("out_real expected %0d got %0d", $signed(want.re), $signed(got.re));
               if (got.im != want.im)
                  $error("out_imag expected %0d got %0d", $signed(want.im), $signed(got.im));
               if (got.wgt != want.wgt)
                  $error("weight expected %0d got %0d", want.wgt, got.wgt);
            end
         end
      end
   end

endmodule

[verif/fourier_transfer_filter_test.sv]
// Top of the transfer filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fourier_transfer_filter_test;
   import ftf_pkg::*;

   localparam int WATCHDOG = 20000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [IDX_W-1:0]         req_index_axis0 = '0;
   logic [IDX_W-1:0]         req_index_axis1 = '0;
   logic [IDX_W-1:0]         req_index_axis2 = '0;
   logic signed [COEF_W-1:0] req_coef_real = '0;
   logic signed [COEF_W-1:0] req_coef_imag = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [COEF_W-1:0] rsp_out_real;
   logic signed [COEF_W-1:0] rsp_out_imag;
   logic [WGT_W-1:0]         rsp_weight;
   int                       fail_count;
   int                       pending;
   bit                       quiet_tail = 1'b0;
   int                       idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fourier_transfer_filter u_top (.*);
   fourier_transfer_filter_checker u_checker (.*);

   // The watchdog ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver stalls in random bursts until the tail of the run.
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 1)) begin
            gap = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(input logic [IDX_W-1:0] i0, i1, i2,
                            input logic signed [COEF_W-1:0] cr, ci, input bit may_gap);
      if (may_gap && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_index_axis0 <= i0;
      req_index_axis1 <= i1;
      req_index_axis2 <= i2;
      req_coef_real   <= cr;
      req_coef_imag   <= ci;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] rand_coef;
      case ($urandom_range(0, 4))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] rand_idx;
      // Low and high indices map to small frequencies, where the cut is decided.
      case ($urandom_range(0, 3))
         0: return IDX_W'($urandom_range(0, 12));
         1: return 8'(256 - $urandom_range(1, 12));
         default: return IDX_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] smooth_set [6] = '{0, 1, 8000, 32768, 40000, 65535};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset settings: index extremes and wrap point.
      send_item(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_item(128, 128, 128, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_item(255, 1, 129, -1, 1, 0);
      send_item(127, 129, 255, 12345, -12345, 0);
      send_item(64, 0, 192, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      drain();
      write_reg(REG_MODE, 48'(MODE_CIC));
      foreach (smooth_set[s]) begin
         write_reg(REG_SMOOTHER, smooth_set[s]);
         send_item(128, 128, 128, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
         send_item(3, 250, 64, -7, 32'sh4000_0000, 0);
         drain();
      end
      write_reg(REG_CUT, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_KSCALE0, 48'hFF_FFFF);
      write_reg(REG_KSCALE1, 48'h00_0001);
      write_reg(REG_KSCALE2, 48'h06_4880);
      for (int m = 1; m <= 3; m++) begin
         write_reg(REG_MODE, 48'(m));
         send_item(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
         send_item(1, 128, 0, -3, 5, 0);
         send_item(0, 128, 2, 99, -99, 0);
         drain();
      end

      // Random phases, each under fresh settings; the smoother changes every third phase.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 11) quiet_tail = 1'b1;
         write_reg(REG_MODE, 48'($urandom_range(0, 3)));
         if (ph % 3 == 0) write_reg(REG_SMOOTHER, 48'($urandom_range(0, 65535)));
         write_reg(REG_CUT, 48'({$urandom, $urandom}) & 48'($urandom_range(0, 1) ?
                   48'hFFFF_FFFF_FFFF : 48'h00FF_FFFF_FFFF));
         write_reg(REG_KSCALE0, 48'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000)));
         write_reg(REG_KSCALE1, 48'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000)));
         write_reg(REG_KSCALE2, 48'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000)));
         for (int n = 0; n < 50; n++)
            send_item(rand_idx(), rand_idx(), rand_idx(), rand_coef(), rand_coef(), 1);
         drain();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
